/* hw/rtl/i2cm_pkg.sv */
// Shared types and constants for the I2C master bit engine.
`default_nettype none

package i2cm_pkg;

  localparam int unsigned TicksW = 8;
  localparam int unsigned PollW  = 10;
  localparam int unsigned DelayW = 10;
  localparam int unsigned CfgW   = 10;

  localparam logic [TicksW-1:0] TicksReset = TicksW'(24);
  localparam logic [PollW-1:0]  PollReset  = PollW'(250);

  typedef enum logic [2:0] {
    ActTick  = 3'd0,
    ActStart = 3'd1,
    ActStop  = 3'd2,
    ActWrite = 3'd3,
    ActRead  = 3'd4,
    ActAck   = 3'd5,
    ActNack  = 3'd6,
    ActWait  = 3'd7
  } action_e;

  typedef enum logic {
    CfgTicksPerUnit = 1'b0,
    CfgAckPollLimit = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_data;
    logic       sda_level;
  } i2cm_in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       ack_status;
  } i2cm_res_t;

  typedef struct packed {
    logic                we;
    cfg_index_e          index;
    logic [CfgW-1:0]     data;
  } i2cm_cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/i2cm_core.sv */
// Bus phase sequencer: config registers, engine state and next-word logic.
`default_nettype none

module i2cm_core import i2cm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire i2cm_in_t  in_i,
  input  wire i2cm_cfg_t cfg_i,
  output i2cm_res_t      res_o
);

  typedef enum logic [3:0] {
    PhIdle, PhSt1, PhSt2, PhSp1, PhSp2, PhAk1, PhAk2,
    PhWrSet, PhWrHi, PhWrLo, PhRdLo, PhRdHi, PhWa1, PhWa2, PhWaPoll
  } phase_e;

  logic [TicksW-1:0] ticks_q;
  logic [PollW-1:0]  limit_q;
  phase_e            phase_q, phase_d;
  logic [3:0]        bit_cnt_q, bit_cnt_d;
  logic [7:0]        shift_q, shift_d;
  logic [DelayW-1:0] delay_q, delay_d;
  logic [PollW-1:0]  poll_q, poll_d;
  logic              scl_q, scl_d, sda_q, sda_d;
  logic [7:0]        rx_q, rx_d;
  logic              ack_q, ack_d;
  logic              done_d;

  logic [TicksW-1:0] tpu;
  logic [DelayW-1:0] dly1, dly2, dly4;
  logic [PollW:0]    poll_inc;
  logic [3:0]        bit_inc;
  logic [7:0]        shift_rd;

  assign tpu      = (ticks_q == '0) ? TicksW'(1) : ticks_q;
  assign dly1     = DelayW'(tpu);
  assign dly2     = DelayW'({tpu, 1'b0});
  assign dly4     = DelayW'({tpu, 2'b00});
  assign poll_inc = {1'b0, poll_q} + (PollW+1)'(1);
  assign bit_inc  = bit_cnt_q + 4'd1;
  assign shift_rd = {shift_q[6:0], in_i.sda_level};

  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    delay_d   = delay_q;
    poll_d    = poll_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    rx_d      = rx_q;
    ack_d     = ack_q;
    done_d    = 1'b0;
    if (phase_q == PhIdle) begin
      case (action_e'(in_i.action))
        ActStart: begin
          phase_d = PhSt1; scl_d = 1'b1; sda_d = 1'b1; delay_d = dly4;
        end
        ActStop: begin
          phase_d = PhSp1; scl_d = 1'b0; sda_d = 1'b0; delay_d = dly4;
        end
        ActWrite: begin
          bit_cnt_d = '0; shift_d = {in_i.tx_data[6:0], 1'b0};
          phase_d = PhWrSet; scl_d = 1'b0; sda_d = in_i.tx_data[7]; delay_d = dly2;
        end
        ActRead: begin
          bit_cnt_d = '0; shift_d = '0;
          phase_d = PhRdLo; scl_d = 1'b0; sda_d = 1'b1; delay_d = dly2;
        end
        ActAck: begin
          phase_d = PhAk1; scl_d = 1'b0; sda_d = 1'b0; delay_d = dly2;
        end
        ActNack: begin
          phase_d = PhAk1; scl_d = 1'b0; sda_d = 1'b1; delay_d = dly2;
        end
        ActWait: begin
          poll_d = '0; phase_d = PhWa1; sda_d = 1'b1; delay_d = dly1;
        end
        default: ;
      endcase
    end else if (phase_q == PhWaPoll) begin
      if (!in_i.sda_level) begin
        scl_d = 1'b0; ack_d = 1'b0; phase_d = PhIdle; done_d = 1'b1;
      end else if (poll_inc > {1'b0, limit_q}) begin
        ack_d = 1'b1;
        phase_d = PhSp1; scl_d = 1'b0; sda_d = 1'b0; delay_d = dly4;
      end else begin
        poll_d = poll_inc[PollW-1:0];
      end
    end else if (delay_q > DelayW'(1)) begin
      delay_d = delay_q - DelayW'(1);
    end else begin
      delay_d = '0;
      unique case (phase_q)
        PhSt1: begin phase_d = PhSt2; scl_d = 1'b1; sda_d = 1'b0; delay_d = dly4; end
        PhSt2: begin scl_d = 1'b0; phase_d = PhIdle; done_d = 1'b1; end
        PhSp1: begin phase_d = PhSp2; scl_d = 1'b1; sda_d = 1'b1; delay_d = dly4; end
        PhSp2: begin phase_d = PhIdle; done_d = 1'b1; end
        PhAk1: begin phase_d = PhAk2; scl_d = 1'b1; delay_d = dly2; end
        PhAk2: begin scl_d = 1'b0; phase_d = PhIdle; done_d = 1'b1; end
        PhWrSet: begin phase_d = PhWrHi; scl_d = 1'b1; delay_d = dly2; end
        PhWrHi: begin phase_d = PhWrLo; scl_d = 1'b0; delay_d = dly2; end
        PhWrLo: begin
          bit_cnt_d = bit_inc;
          if (bit_inc[3]) begin
            phase_d = PhIdle; done_d = 1'b1;
          end else begin
            sda_d = shift_q[7]; shift_d = {shift_q[6:0], 1'b0};
            phase_d = PhWrSet; scl_d = 1'b0; delay_d = dly2;
          end
        end
        PhRdLo: begin phase_d = PhRdHi; scl_d = 1'b1; sda_d = 1'b1; delay_d = dly1; end
        PhRdHi: begin
          shift_d = shift_rd; bit_cnt_d = bit_inc;
          if (bit_inc[3]) begin
            rx_d = shift_rd; phase_d = PhIdle; done_d = 1'b1;
          end else begin
            phase_d = PhRdLo; scl_d = 1'b0; sda_d = 1'b1; delay_d = dly2;
          end
        end
        PhWa1: begin phase_d = PhWa2; scl_d = 1'b1; sda_d = 1'b1; delay_d = dly1; end
        PhWa2: begin phase_d = PhWaPoll; poll_d = '0; delay_d = '0; end
        default: phase_d = PhIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q   <= TicksReset;
      limit_q   <= PollReset;
      phase_q   <= PhIdle;
      bit_cnt_q <= '0;
      shift_q   <= '0;
      delay_q   <= '0;
      poll_q    <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      rx_q      <= '0;
      ack_q     <= 1'b0;
    end else begin
      if (cfg_i.we) begin
        unique case (cfg_i.index)
          CfgTicksPerUnit: ticks_q <= cfg_i.data[TicksW-1:0];
          CfgAckPollLimit: limit_q <= cfg_i.data[PollW-1:0];
          default: ;
        endcase
      end
      if (step_i) begin
        phase_q   <= phase_d;
        bit_cnt_q <= bit_cnt_d;
        shift_q   <= shift_d;
        delay_q   <= delay_d;
        poll_q    <= poll_d;
        scl_q     <= scl_d;
        sda_q     <= sda_d;
        rx_q      <= rx_d;
        ack_q     <= ack_d;
      end
    end
  end

  always_comb begin
    res_o.scl_out    = scl_d;
    res_o.sda_out    = sda_d;
    res_o.busy_res   = (phase_d != PhIdle);
    res_o.done_res   = done_d;
    res_o.rx_data    = rx_d;
    res_o.ack_status = ack_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/i2cm_out_reg.sv */
// Result word register between the engine and the output channel.
`default_nettype none

module i2cm_out_reg import i2cm_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire i2cm_res_t data_i,
  output logic           free_o,
  output logic           valid_o,
  input  wire logic      ready_i,
  output i2cm_res_t      data_o
);

  logic      valid_q;
  i2cm_res_t data_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/i2c_master_bit_engine_top.sv */
// Top level of the I2C master bit engine.
//
// One input word is one clock tick of the engine: an optional command, the
// byte to send and the sampled SDA level. Every accepted word yields exactly
// one result word with the SCL/SDA drive, busy, a done pulse, the last
// received byte and the last acknowledge status.
// The result of an accepted word is offered on out_valid_o from the next
// cycle. Throughput is one word per cycle while the receiver takes each
// result, set by the single result register after the phase logic.
// When the receiver stalls, the result is held and in_ready_o drops until
// that word is taken; ready rises again in the same cycle it is taken.
// Configuration (ticks per unit, ack poll limit) is written on the cfg port
// at any time, cfg_ready_o is always high; write only while the engine is
// idle. Reset releases SCL and SDA, idles the engine, empties the result
// register and loads 24 ticks per unit and a poll limit of 250.
`default_nettype none

module i2c_master_bit_engine_top import i2cm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire i2cm_in_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output i2cm_res_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [CfgW-1:0] cfg_data_i
);

  logic      step;
  i2cm_cfg_t cfg;
  i2cm_res_t res;

  assign cfg_ready_o = 1'b1;
  assign step        = in_valid_i && in_ready_o;

  always_comb begin
    cfg.we    = cfg_valid_i;
    cfg.index = cfg_index_e'(cfg_index_i);
    cfg.data  = cfg_data_i;
  end

  i2cm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .in_i   (in_data_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  i2cm_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .data_i  (res),
    .free_o  (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  a_accept_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("accepted word produced no result");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("done pulse while still busy");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

endmodule

`default_nettype wire
